### rtl/swept_circle_earliest_hit_top_assert.svh
// Assertion macros used by the checker file of the earliest-hit block.
// Each expects signals named clk and arst_n at the place of use.
`ifndef SWEPT_CIRCLE_EARLIEST_HIT_TOP_ASSERT_SVH
`define SWEPT_CIRCLE_EARLIEST_HIT_TOP_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define SCEH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define SCEH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sceh_pkg.sv
`default_nettype none

package sceh_pkg;

	// Field widths of the item and the result
	localparam int COORD_W   = 24;
	localparam int RADIUS_W  = 23;
	localparam int ID_W      = 32;

	// Fixed-point formats
	localparam int COORD_FRAC_BITS = 8;
	localparam int TIME_FRAC_BITS  = 16;
	localparam int TIME_W          = TIME_FRAC_BITS + 2;
	localparam logic [TIME_W-1:0] TIME_NONE = {2'b10, {TIME_FRAC_BITS{1'b0}}};

	// Internal widths
	localparam int DIFF_W    = COORD_W + 1;      // coordinate difference, signed
	localparam int SQ_W      = 2 * COORD_W + 1;  // sum of two squares, unsigned
	localparam int H_W       = SQ_W + 1;         // dot product, signed
	localparam int PROD_W    = 2 * SQ_W;         // h^2, a*c and discriminant
	localparam int ROOT_W    = SQ_W;             // integer square root
	localparam int ACC_A_W   = 2 * DIFF_W + 2;   // first multiply pass accumulator
	localparam int ACC_B_W   = PROD_W + 2;       // second multiply pass accumulator

	// Step counts of the serial units
	localparam int PROD_STEPS = DIFF_W;
	localparam int QUAD_STEPS = SQ_W;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = TIME_FRAC_BITS + 1;
	localparam int CNT_W      = $clog2(SQ_W + 1);

	// Largest |d|^2 that still counts as a zero-length segment (|d|^2 < 0.0001)
	localparam logic [SQ_W-1:0] SHORT_A_MAX =
		SQ_W'(((64'd1 << (2 * COORD_FRAC_BITS)) - 64'd1) / 64'd10000);

	typedef struct packed {
		logic                       new_search;
		logic signed [COORD_W-1:0]  start_x;
		logic signed [COORD_W-1:0]  start_y;
		logic signed [COORD_W-1:0]  end_x;
		logic signed [COORD_W-1:0]  end_y;
		logic signed [COORD_W-1:0]  centre_x;
		logic signed [COORD_W-1:0]  centre_y;
		logic [RADIUS_W-1:0]        radius;
		logic [ID_W-1:0]            target_id;
	} in_item_t;

	typedef struct packed {
		logic               hit;
		logic [TIME_W-1:0]  hit_time;
		logic [ID_W-1:0]    hit_id;
	} out_item_t;

	// Control of a bit-serial multiply-accumulate unit
	typedef struct packed {
		logic step;   // consume one multiplier bit
		logic first;  // first bit: load instead of accumulate
		logic neg;    // first bit carries negative weight
	} mac_ctrl_t;

endpackage

`default_nettype wire

### rtl/sceh_mac2.sv
`default_nettype none

// Bit-serial sum of two products, multiplier bits taken MSB first.
module sceh_mac2
	import sceh_pkg::*;
#(
	parameter int XW = 25,
	parameter int AW = 52
) (
	input  logic                 clk,
	input  mac_ctrl_t            ctrl,
	input  logic                 b0,
	input  logic                 b1,
	input  logic signed [XW-1:0] x0,
	input  logic signed [XW-1:0] x1,
	output logic signed [AW-1:0] acc
);

	logic signed [XW:0]   t0;
	logic signed [XW:0]   t1;
	logic signed [XW:0]   term;
	logic signed [AW-1:0] term_ext;
	logic signed [AW-1:0] acc_q;

	// Select the partial products of this bit
	always_comb begin
		t0       = b0 ? {x0[XW-1], x0} : '0;
		t1       = b1 ? {x1[XW-1], x1} : '0;
		term     = t0 + t1;
		term_ext = {{(AW-XW-1){term[XW]}}, term};
	end

	// Double and add; the first bit loads, with its sign weight
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (ctrl.first) begin
				acc_q <= ctrl.neg ? -term_ext : term_ext;
			end else begin
				acc_q <= (acc_q <<< 1) + term_ext;
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

### rtl/sceh_isqrt.sv
`default_nettype none

// Restoring integer square root, two radicand bits per cycle.
module sceh_isqrt
	import sceh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] rad,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int REM_W = ROOT_W + 2;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0]  rem_sh;
	logic [REM_W+1:0]  trial;
	logic [REM_W+1:0]  diff;
	logic              fits;
	logic              last;

	// Bring down two bits and try the next root bit
	always_comb begin
		rem_sh = {rem_q, rad_q[PROD_W-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		diff   = rem_sh - trial;
		fits   = rem_sh >= trial;
		last   = cnt_q == CNT_W'(ROOT_STEPS - 1);
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Advance radicand, remainder and root
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

### rtl/sceh_tdiv.sv
`default_nettype none

// Restoring division num / den giving one time bit per cycle (num <= den).
module sceh_tdiv
	import sceh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   num,
	input  logic [SQ_W-1:0]   den,
	output logic              done,
	output logic [TIME_W-1:0] quo
);

	logic              busy_q;
	logic              done_q;
	logic              first_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SQ_W-1:0]   den_q;
	logic [SQ_W-1:0]   rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [SQ_W:0]     x;
	logic [SQ_W:0]     diff;
	logic              fits;
	logic              last;

	// Integer bit first without shifting, then the fraction bits
	always_comb begin
		x    = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
		diff = x - {1'b0, den_q};
		fits = x >= {1'b0, den_q};
		last = cnt_q == CNT_W'(DIV_STEPS - 1);
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= '0;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Advance remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SQ_W-1:0] : x[SQ_W-1:0];
			quo_q <= {quo_q[TIME_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

`default_nettype wire

### rtl/swept_circle_earliest_hit_top.sv
// Earliest hit of a moving segment against a stream of circles.
// Input channel item_valid/item_ready/item carries one segment, circle and
// target id; the result channel result_valid/result_ready/result carries the
// best hit of the current search (flag, Q2.16 time, id) after each item.
// Exactly one result leaves for every accepted item, in order.
// One item is worked on at a time. A short segment or a start point inside
// the circle ends after the first multiply pass, a negative discriminant
// after the second; a full solve runs the bit-serial multiply passes, the
// square root (one root bit per cycle, 49 bits) and the time division one
// after the other.
// A finished result sits in an output register; item_ready returns while it
// waits, so the next item can start. If the receiver stalls, the block holds
// the finished result of the next item until the register frees up.
// Reset clears the search to no hit, time 2.0, id 0, and empties the output.
// new_search clears flag and time (not the id) before the item is tested.
`default_nettype none

module swept_circle_earliest_hit_top
	import sceh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_PROD = 9'b000000010,
		S_EVAL = 9'b000000100,
		S_QUAD = 9'b000001000,
		S_DISC = 9'b000010000,
		S_ROOT = 9'b000100000,
		S_PICK = 9'b001000000,
		S_DIV  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	localparam int N_W = H_W + 1;

	state_t state_q;
	state_t state_nxt;
	logic [CNT_W-1:0] cnt_q;

	logic              best_hit_q;
	logic [TIME_W-1:0] best_time_q;
	logic [ID_W-1:0]   best_id_q;
	logic              result_valid_q;
	out_item_t         result_q;

	logic [ID_W-1:0]          id_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q, px_q, py_q, fx_q, fy_q, r_q;
	logic signed [DIFF_W-1:0] dx_sh_q, dy_sh_q, px_sh_q, py_sh_q, fx_sh_q, fy_sh_q, r_sh_q;
	logic signed [H_W-1:0]    h_q;
	logic [SQ_W-1:0]          a_q;
	logic [SQ_W-1:0]          habs_q;
	logic [SQ_W-1:0]          habs_sh_q;
	logic [SQ_W-1:0]          c_sh_q;
	logic                     cand_ok_q;
	logic [TIME_W-1:0]        cand_t_q;

	logic accept;
	logic cnt_last;
	mac_ctrl_t ctrl_a;
	mac_ctrl_t ctrl_b;

	logic signed [ACC_A_W-1:0] acc_a, acc_p, acc_f, acc_r, acc_h;
	logic signed [ACC_B_W-1:0] acc_hh, acc_ac;

	logic [SQ_W-1:0]       a_val, p2, f2, r2, c_val;
	logic signed [H_W-1:0] h_val;
	logic [H_W-1:0]        h_mag;
	logic                  is_short, p_in, s_in;

	logic signed [ACC_B_W-1:0] disc;
	logic                      disc_neg;
	logic                      root_start, root_done;
	logic [ROOT_W-1:0]         root;

	logic [N_W-1:0]  h_ext, s_ext, a_ext, n1, n2;
	logic            n1_ok, n2_ok;
	logic [SQ_W-1:0] num;
	logic            div_start, div_done;
	logic [TIME_W-1:0] quo;

	logic out_free, finish, take;

	assign item_ready = state_q == S_IDLE;
	assign accept     = item_valid && item_ready;
	assign cnt_last   = (state_q == S_PROD) ? (cnt_q == CNT_W'(PROD_STEPS - 1))
	                                        : (cnt_q == CNT_W'(QUAD_STEPS - 1));

	// Multiply controls: first pass is signed, second unsigned
	always_comb begin
		ctrl_a.step  = state_q == S_PROD;
		ctrl_a.first = cnt_q == '0;
		ctrl_a.neg   = cnt_q == '0;
		ctrl_b.step  = state_q == S_QUAD;
		ctrl_b.first = cnt_q == '0;
		ctrl_b.neg   = 1'b0;
	end

	// First pass: |d|^2, |end-centre|^2, |f|^2, R^2 and f.d
	sceh_mac2 #(.XW(DIFF_W), .AW(ACC_A_W)) u_mac_a (
		.clk(clk), .ctrl(ctrl_a),
		.b0(dx_sh_q[DIFF_W-1]), .b1(dy_sh_q[DIFF_W-1]),
		.x0(dx_q), .x1(dy_q), .acc(acc_a)
	);
	sceh_mac2 #(.XW(DIFF_W), .AW(ACC_A_W)) u_mac_p (
		.clk(clk), .ctrl(ctrl_a),
		.b0(px_sh_q[DIFF_W-1]), .b1(py_sh_q[DIFF_W-1]),
		.x0(px_q), .x1(py_q), .acc(acc_p)
	);
	sceh_mac2 #(.XW(DIFF_W), .AW(ACC_A_W)) u_mac_f (
		.clk(clk), .ctrl(ctrl_a),
		.b0(fx_sh_q[DIFF_W-1]), .b1(fy_sh_q[DIFF_W-1]),
		.x0(fx_q), .x1(fy_q), .acc(acc_f)
	);
	sceh_mac2 #(.XW(DIFF_W), .AW(ACC_A_W)) u_mac_r (
		.clk(clk), .ctrl(ctrl_a),
		.b0(r_sh_q[DIFF_W-1]), .b1(1'b0),
		.x0(r_q), .x1('0), .acc(acc_r)
	);
	sceh_mac2 #(.XW(DIFF_W), .AW(ACC_A_W)) u_mac_h (
		.clk(clk), .ctrl(ctrl_a),
		.b0(dx_sh_q[DIFF_W-1]), .b1(dy_sh_q[DIFF_W-1]),
		.x0(fx_q), .x1(fy_q), .acc(acc_h)
	);

	// Second pass: h^2 and a*c
	sceh_mac2 #(.XW(H_W), .AW(ACC_B_W)) u_mac_hh (
		.clk(clk), .ctrl(ctrl_b),
		.b0(habs_sh_q[SQ_W-1]), .b1(1'b0),
		.x0({1'b0, habs_q}), .x1('0), .acc(acc_hh)
	);
	sceh_mac2 #(.XW(H_W), .AW(ACC_B_W)) u_mac_ac (
		.clk(clk), .ctrl(ctrl_b),
		.b0(c_sh_q[SQ_W-1]), .b1(1'b0),
		.x0({1'b0, a_q}), .x1('0), .acc(acc_ac)
	);

	// Classify the item after the first pass
	always_comb begin
		a_val    = acc_a[SQ_W-1:0];
		p2       = acc_p[SQ_W-1:0];
		f2       = acc_f[SQ_W-1:0];
		r2       = acc_r[SQ_W-1:0];
		h_val    = acc_h[H_W-1:0];
		h_mag    = h_val[H_W-1] ? -h_val : h_val;
		c_val    = f2 - r2;
		is_short = a_val <= SHORT_A_MAX;
		p_in     = p2 <= r2;
		s_in     = f2 < r2;
	end

	// Discriminant and root start
	always_comb begin
		disc       = acc_hh - acc_ac;
		disc_neg   = disc[ACC_B_W-1];
		root_start = (state_q == S_DISC) && !disc_neg;
	end

	sceh_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(root_start),
		.rad(disc[PROD_W-1:0]), .done(root_done), .root(root)
	);

	// Pick the entry root, else the exit root, inside [0, a]
	always_comb begin
		h_ext     = {h_q[H_W-1], h_q};
		s_ext     = {2'b00, root};
		a_ext     = {2'b00, a_q};
		n1        = -h_ext - s_ext;
		n2        = s_ext - h_ext;
		n1_ok     = !n1[N_W-1] && (n1 <= a_ext);
		n2_ok     = !n2[N_W-1] && (n2 <= a_ext);
		num       = n1_ok ? n1[SQ_W-1:0] : n2[SQ_W-1:0];
		div_start = (state_q == S_PICK) && (n1_ok || n2_ok);
	end

	sceh_tdiv u_tdiv (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num), .den(a_q), .done(div_done), .quo(quo)
	);

	// Sequence the item through the passes
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (accept) state_nxt = S_PROD;
			S_PROD: if (cnt_last) state_nxt = S_EVAL;
			S_EVAL: state_nxt = (is_short || s_in) ? S_DONE : S_QUAD;
			S_QUAD: if (cnt_last) state_nxt = S_DISC;
			S_DISC: state_nxt = disc_neg ? S_DONE : S_ROOT;
			S_ROOT: if (root_done) state_nxt = S_PICK;
			S_PICK: state_nxt = (n1_ok || n2_ok) ? S_DIV : S_DONE;
			S_DIV:  if (div_done) state_nxt = S_DONE;
			S_DONE: if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	// Apply the candidate when the output register can take the result
	always_comb begin
		out_free = !result_valid_q || result_ready;
		finish   = (state_q == S_DONE) && out_free;
		take     = cand_ok_q && (cand_t_q < best_time_q);
	end

	// Control and search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			best_hit_q     <= 1'b0;
			best_time_q    <= TIME_NONE;
			best_id_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == S_PROD || state_q == S_QUAD) && !cnt_last) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (accept && item.new_search) begin
				best_hit_q  <= 1'b0;
				best_time_q <= TIME_NONE;
			end
			if (finish && take) begin
				best_hit_q  <= 1'b1;
				best_time_q <= cand_t_q;
				best_id_q   <= id_q;
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Item operands and serial shift copies
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= item.target_id;
			dx_q    <= {item.end_x[COORD_W-1], item.end_x}
			         - {item.start_x[COORD_W-1], item.start_x};
			dy_q    <= {item.end_y[COORD_W-1], item.end_y}
			         - {item.start_y[COORD_W-1], item.start_y};
			px_q    <= {item.end_x[COORD_W-1], item.end_x}
			         - {item.centre_x[COORD_W-1], item.centre_x};
			py_q    <= {item.end_y[COORD_W-1], item.end_y}
			         - {item.centre_y[COORD_W-1], item.centre_y};
			fx_q    <= {item.start_x[COORD_W-1], item.start_x}
			         - {item.centre_x[COORD_W-1], item.centre_x};
			fy_q    <= {item.start_y[COORD_W-1], item.start_y}
			         - {item.centre_y[COORD_W-1], item.centre_y};
			r_q     <= {2'b00, item.radius};
			dx_sh_q <= {item.end_x[COORD_W-1], item.end_x}
			         - {item.start_x[COORD_W-1], item.start_x};
			dy_sh_q <= {item.end_y[COORD_W-1], item.end_y}
			         - {item.start_y[COORD_W-1], item.start_y};
			px_sh_q <= {item.end_x[COORD_W-1], item.end_x}
			         - {item.centre_x[COORD_W-1], item.centre_x};
			py_sh_q <= {item.end_y[COORD_W-1], item.end_y}
			         - {item.centre_y[COORD_W-1], item.centre_y};
			fx_sh_q <= {item.start_x[COORD_W-1], item.start_x}
			         - {item.centre_x[COORD_W-1], item.centre_x};
			fy_sh_q <= {item.start_y[COORD_W-1], item.start_y}
			         - {item.centre_y[COORD_W-1], item.centre_y};
			r_sh_q  <= {2'b00, item.radius};
		end else if (state_q == S_PROD) begin
			dx_sh_q <= dx_sh_q << 1;
			dy_sh_q <= dy_sh_q << 1;
			px_sh_q <= px_sh_q << 1;
			py_sh_q <= py_sh_q << 1;
			fx_sh_q <= fx_sh_q << 1;
			fy_sh_q <= fy_sh_q << 1;
			r_sh_q  <= r_sh_q << 1;
		end
	end

	// Second pass operands
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			h_q       <= h_val;
			a_q       <= a_val;
			habs_q    <= h_mag[SQ_W-1:0];
			habs_sh_q <= h_mag[SQ_W-1:0];
			c_sh_q    <= c_val;
		end else if (state_q == S_QUAD) begin
			habs_sh_q <= habs_sh_q << 1;
			c_sh_q    <= c_sh_q << 1;
		end
	end

	// Candidate hit of the current item
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			cand_ok_q <= is_short ? p_in : s_in;
			cand_t_q  <= '0;
		end else if (state_q == S_DISC && disc_neg) begin
			cand_ok_q <= 1'b0;
		end else if (state_q == S_PICK && !(n1_ok || n2_ok)) begin
			cand_ok_q <= 1'b0;
		end else if (state_q == S_DIV && div_done) begin
			cand_ok_q <= 1'b1;
			cand_t_q  <= quo;
		end
	end

	// Output register holds the search state after this item
	always_ff @(posedge clk) begin
		if (finish) begin
			result_q.hit      <= take ? 1'b1 : best_hit_q;
			result_q.hit_time <= take ? cand_t_q : best_time_q;
			result_q.hit_id   <= take ? id_q : best_id_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

### rtl/sceh_checker.sv
`default_nettype none

`include "swept_circle_earliest_hit_top_assert.svh"

module sceh_checker
	import sceh_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      item_valid,
	input logic      item_ready,
	input logic      result_valid,
	input logic      result_ready,
	input out_item_t result
);

	// A stalled result stays put
	`SCEH_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")

	// No hit exactly when the time reads 2.0
	`SCEH_ASSERT_NOW(a_hit_time_agree, result_valid, result.hit != (result.hit_time == TIME_NONE), "hit flag and hit time disagree")

	// One item in work at a time
	`SCEH_ASSERT_NEXT(a_one_in_work, item_valid && item_ready, !item_ready, "input ready right after an accepted transaction")

endmodule

bind swept_circle_earliest_hit_top sceh_checker u_sceh_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

`default_nettype wire
